// ----- src/grid_walk_count_matrix_power_top_macros.svh -----
// assertion macros for the walk counter
`ifndef GRID_WALK_COUNT_MATRIX_POWER_TOP_MACROS_SVH
`define GRID_WALK_COUNT_MATRIX_POWER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define GW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define GW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/gwcmp_pkg.sv -----
`timescale 1ns / 1ps
package gwcmp_pkg;
    localparam int MAX_CELLS_DEF = 32;
    localparam logic [29:0] MODULUS = 30'd1000000007;
    localparam logic [1:0] KIND_QUERY   = 2'd0;
    localparam logic [1:0] KIND_BLOCK   = 2'd1;
    localparam logic [1:0] KIND_UNBLOCK = 2'd2;
    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUILD, ST_CHECK, ST_APPLY, ST_APPLY_CP, ST_SQUARE,
        ST_SQUARE_CP, ST_EVENT, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [29:0] acc;
        logic [29:0] a;
        logic [29:0] b;
    } mac_req_t;

    // conditional subtract for values below 2*MODULUS
    function automatic logic [29:0] mod_fold(input logic [30:0] v);
        logic [30:0] d;
        d = v - {1'b0, MODULUS};
        return v >= {1'b0, MODULUS} ? d[29:0] : v[29:0];
    endfunction
endpackage

// ----- src/grid_walk_count_matrix_power_top.sv -----
`timescale 1ns / 1ps
// a request with no elapsed time goes from ST_BUILD straight to ST_EVENT;
// otherwise ST_BUILD fills the step matrix, then per bit of the elapsed time a vector
// product (set bits only) and, below the top bit, a squaring, each made of mac ops;
// a mac op is bit-serial; a query's result then waits in ST_OUT until it is taken
// one request at a time; ready is low until the request is done or its result taken
// reset: async active low; count is one at cell 0, all open, last time one
module grid_walk_count_matrix_power_top
    import gwcmp_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [31:0] event_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [29:0] walk_count
);
    `include "grid_walk_count_matrix_power_top_macros.svh"

    localparam int CW = $clog2(MAX_CELLS + 1);          // count width
    localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int MD = MAX_CELLS * MAX_CELLS;
    localparam int MW = $clog2(MD) > 0 ? $clog2(MD) : 1;

    // configuration registers
    logic [5:0] rows_reg, cols_reg;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 6'd1;
            cols_reg <= 6'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_ROWS) rows_reg <= pwdata[5:0];
            if (paddr == ADDR_COLS) cols_reg <= pwdata[5:0];
        end
    end
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_ROWS) prdata = {26'd0, rows_reg};
        else if (paddr == ADDR_COLS) prdata = {26'd0, cols_reg};
    end

    // matrices: base and scratch product memories, one write and one read port each
    logic [29:0] base_mem [MD];
    logic [29:0] pow_mem  [MD];

    state_t state_reg, state_next;
    logic [CW-1:0] nc_reg, nc_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [31:0]   delta_reg, delta_next;
    logic [31:0]   last_reg, last_next;
    logic [29:0]   acc_reg, acc_next;
    logic [1:0]    kind_reg;
    logic [5:0]    row_reg, col_reg;
    logic [29:0]   out_reg, out_next;
    logic [1:0]    ph_reg, ph_next;   // phase of a mac op; the last one waits for mac done
    logic [29:0]   opa_reg, opa_next;
    logic [MAX_CELLS-1:0] blk_reg, blk_next;
    logic [29:0]   vec_reg [MAX_CELLS];
    logic [29:0]   svec_reg [MAX_CELLS];
    // grid row and column of cell j, stepped along with j during build
    logic [5:0]    brow_reg, brow_next, bcol_reg, bcol_next;

    // memory ports
    logic          bw_en, pw_en;
    logic [MW-1:0] b_waddr, b_raddr, p_waddr, p_raddr;
    logic [29:0]   b_wdata, p_wdata, b_rdata, p_rdata;

    always_ff @(posedge clk)
    begin
        if (bw_en) base_mem[b_waddr] <= b_wdata;
        b_rdata <= base_mem[b_raddr];
        if (pw_en) pow_mem[p_waddr] <= p_wdata;
        p_rdata <= pow_mem[p_raddr];
    end

    mac_req_t mreq;
    logic     mdone;
    logic [29:0] mres;
    gwcmp_mac u_mac (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .result(mres));

    function automatic logic [MW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        logic [2*CW-1:0] v;
        v = {{CW{1'b0}}, r} * (2*CW)'(MAX_CELLS) + {{CW{1'b0}}, c};
        return v[MW-1:0];
    endfunction

    // base entry for destination b from source a (row index a, col b)
    logic [CW-1:0] bb, ba;
    logic [11:0]   bcell_r, bcell_c;
    logic          bval;
    always_comb
    begin
        bb = j_reg;
        ba = i_reg;
        bcell_r = {6'd0, brow_reg};
        bcell_c = {6'd0, bcol_reg};
        bval = 1'b0;
        if (!blk_reg[bb[IW-1:0]])
        begin
            if (ba == bb) bval = 1'b1;
            if (bcell_c > 0 && ba + 1 == bb) bval = 1'b1;
            if (bcell_c + 1 < cols_reg && ba == bb + 1) bval = 1'b1;
            if (bcell_r > 0 && 12'(ba) + 12'(cols_reg) == 12'(bb)) bval = 1'b1;
            if (bcell_r + 1 < rows_reg && 12'(ba) == 12'(bb) + 12'(cols_reg)) bval = 1'b1;
        end
    end

    // event address decode
    logic [11:0] prod, cell12;
    logic        evalid;
    always_comb
    begin
        prod = 12'(rows_reg) * 12'(cols_reg);
        cell12 = (12'(row_reg) - 12'd1) * 12'(cols_reg) + 12'(col_reg) - 12'd1;
        evalid = row_reg >= 6'd1 && col_reg >= 6'd1 && row_reg <= rows_reg &&
                 col_reg <= cols_reg && cell12 < 12'(MAX_CELLS);
    end

    logic vec_we, svec_we, vec_copy, evt_clear;
    always_comb
    begin
        state_next = state_reg;
        nc_next = nc_reg; i_next = i_reg; j_next = j_reg; k_next = k_reg;
        delta_next = delta_reg; last_next = last_reg; acc_next = acc_reg;
        out_next = out_reg; ph_next = ph_reg; opa_next = opa_reg; blk_next = blk_reg;
        brow_next = brow_reg; bcol_next = bcol_reg;
        bw_en = 1'b0; pw_en = 1'b0;
        b_waddr = maddr(i_reg, j_reg); b_wdata = {29'd0, bval};
        b_raddr = maddr(i_reg, j_reg); p_waddr = maddr(i_reg, k_reg);
        p_wdata = mres; p_raddr = maddr(i_reg, j_reg);
        mreq = '0;
        vec_we = 1'b0; svec_we = 1'b0; vec_copy = 1'b0; evt_clear = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    nc_next = (prod > 12'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(prod);
                    delta_next = (event_time >= last_reg) ? event_time - last_reg : 32'd0;
                    last_next = event_time;
                    i_next = '0; j_next = '0;
                    brow_next = '0; bcol_next = '0;
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (delta_reg == 0 || nc_reg == 0) state_next = ST_EVENT;
                else
                begin
                    bw_en = 1'b1;
                    if (j_reg + 1 == nc_reg)
                    begin
                        j_next = '0;
                        brow_next = '0; bcol_next = '0;
                        if (i_reg + 1 == nc_reg) begin i_next = '0; state_next = ST_CHECK; end
                        else i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        if (bcol_reg + 6'd1 == cols_reg)
                        begin
                            bcol_next = '0; brow_next = brow_reg + 6'd1;
                        end
                        else bcol_next = bcol_reg + 6'd1;
                    end
                end
            end
            ST_CHECK:
            begin
                i_next = '0; j_next = '0; k_next = '0; ph_next = 2'd0; acc_next = '0;
                if (delta_reg == 0) state_next = ST_EVENT;
                else if (delta_reg[0]) state_next = ST_APPLY;
                else state_next = ST_SQUARE;
            end
            ST_APPLY:
            begin
                // svec[j] = sum_i vec[i]*base[i][j]; i from i_reg
                b_raddr = maddr(i_reg, j_reg);
                unique case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1:
                    begin
                        mreq.start = 1'b1; mreq.acc = acc_reg;
                        mreq.a = vec_reg[i_reg[IW-1:0]]; mreq.b = b_rdata;
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        if (mdone)
                        begin
                            ph_next = 2'd0;
                            if (i_reg + 1 == nc_reg)
                            begin
                                svec_we = 1'b1; acc_next = '0; i_next = '0;
                                if (j_reg + 1 == nc_reg)
                                begin
                                    j_next = '0; state_next = ST_APPLY_CP;
                                end
                                else j_next = j_reg + 1'b1;
                            end
                            else begin acc_next = mres; i_next = i_reg + 1'b1; end
                        end
                    end
                endcase
            end
            ST_APPLY_CP:
            begin
                vec_copy = 1'b1;
                if (delta_reg[31:1] != 0) begin ph_next = 2'd0; state_next = ST_SQUARE; end
                else begin delta_next = '0; state_next = ST_EVENT; end
            end
            ST_SQUARE:
            begin
                // pow[i][k] = sum_j base[i][j]*base[j][k]
                if (delta_reg[31:1] == 0) begin delta_next = '0; state_next = ST_EVENT; end
                else
                unique case (ph_reg)
                    2'd0: begin b_raddr = maddr(i_reg, j_reg); ph_next = 2'd1; end
                    2'd1: begin
                        opa_next = b_rdata; b_raddr = maddr(j_reg, k_reg); ph_next = 2'd2;
                    end
                    2'd2: begin
                        mreq.start = 1'b1; mreq.acc = acc_reg; mreq.a = opa_reg;
                        mreq.b = b_rdata; ph_next = 2'd3;
                    end
                    default:
                    begin
                        if (mdone)
                        begin
                            ph_next = 2'd0;
                            if (j_reg + 1 == nc_reg)
                            begin
                                pw_en = 1'b1; acc_next = '0; j_next = '0;
                                if (k_reg + 1 == nc_reg)
                                begin
                                    k_next = '0;
                                    if (i_reg + 1 == nc_reg)
                                    begin
                                        i_next = '0; ph_next = 2'd0;
                                        state_next = ST_SQUARE_CP;
                                    end
                                    else i_next = i_reg + 1'b1;
                                end
                                else k_next = k_reg + 1'b1;
                            end
                            else begin acc_next = mres; j_next = j_reg + 1'b1; end
                        end
                    end
                endcase
            end
            ST_SQUARE_CP:
            begin
                // copy pow into base, reading an entry in phase 0 and writing it in phase 1
                p_raddr = maddr(i_reg, j_reg);
                b_waddr = maddr(i_reg, j_reg);
                b_wdata = p_rdata;
                if (ph_reg == 2'd0) ph_next = 2'd1;
                else
                begin
                    bw_en = 1'b1; ph_next = 2'd0;
                    if (j_reg + 1 == nc_reg)
                    begin
                        j_next = '0;
                        if (i_reg + 1 == nc_reg)
                        begin
                            i_next = '0; delta_next = delta_reg >> 1; state_next = ST_CHECK;
                        end
                        else i_next = i_reg + 1'b1;
                    end
                    else j_next = j_reg + 1'b1;
                end
            end
            ST_EVENT:
            begin
                out_next = evalid ? vec_reg[cell12[IW-1:0]] : 30'd0;
                if (evalid && kind_reg == KIND_BLOCK)
                begin
                    blk_next[cell12[IW-1:0]] = 1'b1; evt_clear = 1'b1;
                end
                else if (evalid && kind_reg == KIND_UNBLOCK) blk_next[cell12[IW-1:0]] = 1'b0;
                state_next = (kind_reg == KIND_QUERY) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // squaring is skipped after the top bit, so delta is cleared there instead of shifted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg <= 32'd1;
            blk_reg <= '0;
            ph_reg <= 2'd0;
            for (int n = 0; n < MAX_CELLS; n++) vec_reg[n] <= (n == 0) ? 30'd1 : 30'd0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            blk_reg <= blk_next;
            ph_reg <= ph_next;
            if (vec_copy)
                for (int n = 0; n < MAX_CELLS; n++)
                    if (n < nc_reg) vec_reg[n] <= svec_reg[n];
            if (evt_clear) vec_reg[cell12[IW-1:0]] <= 30'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        nc_reg <= nc_next; i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
        delta_reg <= delta_next; acc_reg <= acc_next; out_reg <= out_next;
        opa_reg <= opa_next;
        brow_reg <= brow_next; bcol_reg <= bcol_next;
        if (svec_we) svec_reg[j_reg[IW-1:0]] <= mres;
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg <= kind; row_reg <= row; col_reg <= col;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign walk_count = out_reg;

    `GW_ASSERT_IMP(a_out_below_mod, out_valid, walk_count < MODULUS)
    `GW_ASSERT_IMP(a_not_both, out_valid, !in_ready)
    `GW_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
endmodule

// ----- src/gwcmp_mac.sv -----
`timescale 1ns / 1ps
// modular multiply-accumulate: acc + a*b mod p, bit-serial over 30 steps
module gwcmp_mac
    import gwcmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mac_req_t    req,
    output logic        done,
    output logic [29:0] result
);
    logic [29:0] r_reg, r_next;
    logic [29:0] a_reg, a_next;
    logic [29:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [29:0] dbl;
    logic [29:0] add;

    always_comb
    begin
        dbl = mod_fold({r_reg, 1'b0});
        add = mod_fold({1'b0, dbl} + {1'b0, a_reg});
        r_next = r_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            r_next = req.acc;
            a_next = req.a;
            b_next = req.b;
            cnt_next = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // horner on b, msb first; an acc seeded into r would be doubled at every
            // step, so r starts at zero and the seed is added at the end instead
            r_next = b_reg[29] ? add : dbl;
            b_next = {b_reg[28:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    logic [29:0] seed_reg, seed_next;
    always_comb seed_next = req.start ? req.acc : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= req.start ? 30'd0 : r_next;
        a_reg <= a_next;
        b_reg <= b_next;
        seed_reg <= seed_next;
    end

    assign done = done_reg;
    assign result = mod_fold({1'b0, r_reg} + {1'b0, seed_reg});
endmodule
